// ===== rtl/srfe_pkg.sv =====
// Package with the constants, result type and helper functions of the SAM record field extractor.
`default_nettype none

package srfe_pkg;

    localparam logic [3:0] MANDATORY_FIELDS = 4'd11;

    localparam logic [3:0] FIELD_FLAG  = 4'd1;
    localparam logic [3:0] FIELD_POS   = 4'd3;
    localparam logic [3:0] FIELD_CIGAR = 4'd5;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] FLAG_MAX = 32'd65535;
    localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] NM_MAX   = 32'h7FFF_FFFF;
    localparam logic [16:0] MD_MAX   = 17'd65535;
    localparam logic [16:0] MD_NONE  = 17'h1_FFFF;
    localparam logic [31:0] NM_NONE  = 32'hFFFF_FFFF;

    localparam logic [1:0] MD_UNKNOWN  = 2'd0;
    localparam logic [1:0] MD_MATCH    = 2'd1;
    localparam logic [1:0] MD_MISMATCH = 2'd2;
    localparam logic [1:0] MD_DELETION = 2'd3;

    localparam logic [1:0] NM_IDLE  = 2'd0;
    localparam logic [1:0] NM_SKIP  = 2'd1;
    localparam logic [1:0] NM_VALUE = 2'd2;
    localparam logic [1:0] NM_DONE  = 2'd3;

    localparam int RESULT_BITS = 130;
    localparam int TDATA_BITS  = 136;

    typedef struct packed {
        logic [31:0] edit_distance;
        logic [16:0] mismatch_count;
        logic [30:0] alignment_length;
        logic        unmapped;
        logic        forward_strand;
        logic [30:0] ref_position;
        logic [15:0] flag_value;
        logic        record_ok;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        return (c == CH_A) || (c == CH_C) || (c == CH_T) || (c == CH_G);
    endfunction

    function automatic logic [31:0] dec_push(input logic [31:0] acc, input logic [7:0] c,
                                             input logic [31:0] max_val);
        logic [35:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, c[3:0]};
        return (v > {4'd0, max_val}) ? max_val : v[31:0];
    endfunction

    function automatic logic [30:0] sat_add(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] v;
        v = {1'b0, a} + {1'b0, b};
        return (v > POS_MAX) ? POS_MAX[30:0] : v[30:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sam_record_field_extractor.sv =====
// Top level of the SAM record field extractor: input register, parser and output register.
// A line's last byte waits in the input register until the output register is empty or
// being emptied; its summary is then loaded into the output register, which drives m_tvalid.
// Throughput: one byte per cycle; the input register and the output register let a new
// byte enter while a finished summary waits, and only a last byte stalls behind a full output.
// Reset: synchronous and active low; it clears the parser state and both valid flags.
`default_nettype none

module sam_record_field_extractor (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,  // char_byte[7:0]
    input  wire logic                         s_tlast,  // line_end
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // record_ok[0], flag_value[16:1], ref_position[47:17], forward_strand[48],
    // unmapped[49], alignment_length[80:50], mismatch_count[97:81],
    // edit_distance[129:98], zero padding[135:130]
    output logic [srfe_pkg::TDATA_BITS-1:0]   m_tdata
);
    import srfe_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    result_t    result;

    assign advance  = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    srfe_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .char_byte (in_byte_reg),
        .line_end  (in_last_reg),
        .result    (result)
    );

    srfe_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && in_last_reg),
        .load_data (result),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/srfe_parser.sv =====
// Per-byte parser state and its combinational update, giving the line summary on the last byte.
`default_nettype none

module srfe_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        char_byte,
    input  wire logic              line_end,
    output srfe_pkg::result_t      result
);
    import srfe_pkg::*;

    logic [3:0]  field_index_reg, field_index_next;
    logic [15:0] flag_acc_reg, flag_acc_next;
    logic [30:0] pos_acc_reg, pos_acc_next;
    logic        num_stop_reg, num_stop_next;
    logic [30:0] cigar_run_reg, cigar_run_next;
    logic [30:0] cigar_sum_reg, cigar_sum_next;
    logic [15:0] tag_window_reg, tag_window_next;
    logic [1:0]  md_phase_reg, md_phase_next;
    logic [1:0]  md_skip_reg, md_skip_next;
    logic [16:0] md_acc_reg, md_acc_next;
    logic [1:0]  nm_state_reg, nm_state_next;
    logic [1:0]  nm_skip_reg, nm_skip_next;
    logic [31:0] nm_acc_reg, nm_acc_next;

    logic [31:0] push_value;
    logic [1:0]  skip_dec;
    logic [3:0]  field_inc;
    logic        tab;
    logic        digit;
    logic        unm;
    logic [7:0]  p2;
    logic [7:0]  p1;

    always_comb begin
        field_index_next = field_index_reg;
        flag_acc_next    = flag_acc_reg;
        pos_acc_next     = pos_acc_reg;
        num_stop_next    = num_stop_reg;
        cigar_run_next   = cigar_run_reg;
        cigar_sum_next   = cigar_sum_reg;
        tag_window_next  = tag_window_reg;
        md_phase_next    = md_phase_reg;
        md_skip_next     = md_skip_reg;
        md_acc_next      = md_acc_reg;
        nm_state_next    = nm_state_reg;
        nm_skip_next     = nm_skip_reg;
        nm_acc_next      = nm_acc_reg;
        skip_dec         = nm_skip_reg;

        tab       = (char_byte == CH_TAB);
        digit     = is_digit(char_byte);
        field_inc = 4'(field_index_reg + 4'd1);
        p2        = tag_window_reg[15:8];
        p1        = tag_window_reg[7:0];

        push_value = 32'd0;
        if (field_index_reg == FIELD_FLAG) begin
            push_value = dec_push({16'd0, flag_acc_reg}, char_byte, FLAG_MAX);
        end else if (field_index_reg == FIELD_POS) begin
            push_value = dec_push({1'b0, pos_acc_reg}, char_byte, POS_MAX);
        end else if (field_index_reg == FIELD_CIGAR) begin
            push_value = dec_push({1'b0, cigar_run_reg}, char_byte, POS_MAX);
        end else begin
            push_value = dec_push(nm_acc_reg, char_byte, NM_MAX);
        end

        if (field_index_reg < MANDATORY_FIELDS) begin
            if (tab) begin
                field_index_next = field_inc;
                num_stop_next    = 1'b0;
                if (field_inc == MANDATORY_FIELDS) begin
                    tag_window_next = 16'd0;
                end
            end else if (field_index_reg == FIELD_FLAG) begin
                if (!num_stop_reg) begin
                    if (digit) begin
                        flag_acc_next = push_value[15:0];
                    end else begin
                        num_stop_next = 1'b1;
                    end
                end
            end else if (field_index_reg == FIELD_POS) begin
                if (!num_stop_reg) begin
                    if (digit) begin
                        pos_acc_next = push_value[30:0];
                    end else begin
                        num_stop_next = 1'b1;
                    end
                end
            end else if (field_index_reg == FIELD_CIGAR) begin
                if (digit) begin
                    cigar_run_next = push_value[30:0];
                end else begin
                    if (char_byte == CH_M || char_byte == CH_D || char_byte == CH_I) begin
                        cigar_sum_next = sat_add(cigar_sum_reg, cigar_run_reg);
                    end
                    cigar_run_next = 31'd0;
                end
            end
        end else begin
            if (md_skip_reg == 2'd1) begin
                if (tab) begin
                    md_skip_next = 2'd0;
                end else if (md_phase_reg == MD_DELETION) begin
                    md_phase_next = is_base(char_byte) ? MD_DELETION : MD_MATCH;
                end else if (char_byte == CH_CARET) begin
                    md_phase_next = MD_DELETION;
                end else if (is_base(char_byte)) begin
                    md_phase_next = MD_MISMATCH;
                    if (md_acc_reg < MD_MAX) begin
                        md_acc_next = 17'(md_acc_reg + 17'd1);
                    end
                end else begin
                    md_phase_next = MD_MATCH;
                end
            end else if (md_skip_reg >= 2'd2) begin
                md_skip_next = 2'(md_skip_reg - 2'd1);
            end

            if (nm_state_reg == NM_SKIP) begin
                if (nm_skip_reg != 2'd0) begin
                    skip_dec = 2'(nm_skip_reg - 2'd1);
                end
                nm_skip_next = skip_dec;
                if (skip_dec == 2'd0) begin
                    nm_state_next = NM_VALUE;
                end
            end else if (nm_state_reg == NM_VALUE) begin
                if (digit) begin
                    nm_acc_next = push_value;
                end else begin
                    nm_state_next = NM_DONE;
                end
            end

            if (char_byte == CH_COLON && p2 == CH_M && p1 == CH_D) begin
                md_acc_next   = 17'd0;
                md_phase_next = MD_UNKNOWN;
                md_skip_next  = 2'd3;
            end
            if (char_byte == CH_COLON && p2 == CH_N && p1 == CH_M && nm_state_reg == NM_IDLE) begin
                nm_acc_next   = 32'd0;
                nm_state_next = NM_SKIP;
                nm_skip_next  = 2'd2;
            end
            tag_window_next = {p1, char_byte};
        end

        unm = flag_acc_next[2];
        if (field_index_next >= 4'(MANDATORY_FIELDS - 4'd1)) begin
            result.record_ok        = 1'b1;
            result.flag_value       = flag_acc_next;
            result.ref_position     = pos_acc_next;
            result.forward_strand   = ~flag_acc_next[4];
            result.unmapped         = unm;
            result.alignment_length = unm ? 31'd0 : cigar_sum_next;
            result.mismatch_count   = md_acc_next;
            result.edit_distance    = nm_acc_next;
        end else begin
            result.record_ok        = 1'b0;
            result.flag_value       = 16'd0;
            result.ref_position     = 31'd0;
            result.forward_strand   = 1'b0;
            result.unmapped         = 1'b0;
            result.alignment_length = 31'd0;
            result.mismatch_count   = MD_NONE;
            result.edit_distance    = NM_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && line_end)) begin
            field_index_reg <= 4'd0;
            flag_acc_reg    <= 16'd0;
            pos_acc_reg     <= 31'd0;
            num_stop_reg    <= 1'b0;
            cigar_run_reg   <= 31'd0;
            cigar_sum_reg   <= 31'd0;
            tag_window_reg  <= 16'd0;
            md_phase_reg    <= MD_UNKNOWN;
            md_skip_reg     <= 2'd0;
            md_acc_reg      <= MD_NONE;
            nm_state_reg    <= NM_IDLE;
            nm_skip_reg     <= 2'd0;
            nm_acc_reg      <= NM_NONE;
        end else if (step) begin
            field_index_reg <= field_index_next;
            flag_acc_reg    <= flag_acc_next;
            pos_acc_reg     <= pos_acc_next;
            num_stop_reg    <= num_stop_next;
            cigar_run_reg   <= cigar_run_next;
            cigar_sum_reg   <= cigar_sum_next;
            tag_window_reg  <= tag_window_next;
            md_phase_reg    <= md_phase_next;
            md_skip_reg     <= md_skip_next;
            md_acc_reg      <= md_acc_next;
            nm_state_reg    <= nm_state_next;
            nm_skip_reg     <= nm_skip_next;
            nm_acc_reg      <= nm_acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srfe_out_reg.sv =====
// Output register holding one summary beat until the downstream side takes it.
`default_nettype none

module srfe_out_reg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire srfe_pkg::result_t            load_data,
    input  wire logic                         m_tready,
    output logic                              m_tvalid,
    output logic [srfe_pkg::TDATA_BITS-1:0]   m_tdata
);
    import srfe_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(TDATA_BITS - RESULT_BITS)'(0), data_reg};

endmodule

`default_nettype wire

// ===== tb/sv/sam_record_field_extractor_tb.sv =====
// Self-checking testbench for the SAM record field extractor, driven by random and directed lines.
`timescale 1ns / 1ps

module sam_record_field_extractor_tb;
    import srfe_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIR_ROWS      = 13;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic    known;
        result_t val;
    } fixed_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'd0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;

    beat_t      tx_q[$];
    fixed_t     fixed_q[$];
    result_t    summary_q[$];
    logic [7:0] line_buf[$];

    int err_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_ack = 0;
    int hold_left = 0;

    // Parser state of the line in progress.
    int          fld_cnt;
    logic [31:0] flag_val;
    logic [31:0] pos_val;
    logic        num_halt;
    logic [31:0] run_len;
    logic [31:0] len_sum;
    logic [15:0] win;
    logic [1:0]  md_ph;
    logic [1:0]  md_wait;
    logic [16:0] md_cnt;
    logic [1:0]  nm_st;
    logic [1:0]  nm_wait;
    logic [31:0] nm_val;

    string  dir_text [DIR_ROWS] = '{
        "A",
        "\t\t\t\t\t\t\t\t\t\t",
        "\t\t\t\t\t\t\t\t\t",
        "r1\t16\tchr1\t100\t60\t5M2I3D1S4M\t*\t0\t0\tACGT\tIIII\tNM:i:3\tMD:Z:5A^CG2T0",
        "q\t99999999\tc\t99999999999\t0\t5M\t*\t0\t0\t*\t*\tNM:i:99999999999\tMD:Z:",
        "q\t0\tc\t1\t0\t99999999999M1D\t*\t0\t0\t*\t*",
        "r\t4\tc\t7\t0\t10M\t*\t0\t0\tA\tI",
        "r\t-5\tc\t+7\t0\t3X4M2=6I\t*\t0\t0\tA\tI",
        "r\t0\tc\t1\t0\t1M\t*\t0\t0\tA\tI\tMD:Z:AAA\tNM:i:5\tMD:Z:A^ACG^T1C\tNM:i:9",
        "r\t0\tc\t1\t0\t1M\t*\t0\t0\tA\tI\tXA:Z:MD:Z:GG\tXB:Z:NM:i:12x",
        "r\t0\tc\t1\t0\t1M\t*\t0\t0\tA\tI\tNM:i",
        "r\t0\tc\t1\t0\t1M\t*\t0\t0\tA\tI\t\t\377\tMD:Z:\t",
        "r\t 3\tc\t0\t0\t2D\t*\t0\t0\tA\tI\tNM:i:\t"
    };
    fixed_t dir_fix [DIR_ROWS];

    int send_pct_of [4] = '{0, 45, 0, 18};
    int stall_pct_of [4] = '{0, 0, 45, 18};

    sam_record_field_extractor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic is_num_char(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic logic is_nucleotide(input logic [7:0] ch);
        return ch == CH_A || ch == CH_C || ch == CH_G || ch == CH_T;
    endfunction

    function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] ch,
                                              input logic [31:0] cap);
        logic [63:0] v;
        v = 64'(acc) * 64'd10 + 64'(ch - CH_ZERO);
        return (v > 64'(cap)) ? cap : v[31:0];
    endfunction

    function automatic void clear_parser();
        fld_cnt  = 0;
        flag_val = '0;
        pos_val  = '0;
        num_halt = 1'b0;
        run_len  = '0;
        len_sum  = '0;
        win      = '0;
        md_ph    = MD_UNKNOWN;
        md_wait  = '0;
        md_cnt   = MD_NONE;
        nm_st    = NM_IDLE;
        nm_wait  = '0;
        nm_val   = NM_NONE;
    endfunction

    function automatic void tag_byte(input logic [7:0] ch);
        logic [7:0] prev2;
        logic [7:0] prev1;
        prev2 = win[15:8];
        prev1 = win[7:0];
        if (md_wait == 2'd1) begin
            if (ch == CH_TAB) begin
                md_wait = 2'd0;
            end else if (md_ph == MD_DELETION) begin
                md_ph = is_nucleotide(ch) ? MD_DELETION : MD_MATCH;
            end else if (ch == CH_CARET) begin
                md_ph = MD_DELETION;
            end else if (is_nucleotide(ch)) begin
                md_ph = MD_MISMATCH;
                if (md_cnt < MD_MAX) md_cnt = md_cnt + 17'd1;
            end else begin
                md_ph = MD_MATCH;
            end
        end else if (md_wait >= 2'd2) begin
            md_wait = md_wait - 2'd1;
        end
        if (nm_st == NM_SKIP) begin
            if (nm_wait != 2'd0) nm_wait = nm_wait - 2'd1;
            if (nm_wait == 2'd0) nm_st = NM_VALUE;
        end else if (nm_st == NM_VALUE) begin
            if (is_num_char(ch)) nm_val = add_digit(nm_val, ch, NM_MAX);
            else nm_st = NM_DONE;
        end
        if (ch == CH_COLON && prev2 == CH_M && prev1 == CH_D) begin
            md_cnt  = '0;
            md_ph   = MD_UNKNOWN;
            md_wait = 2'd3;
        end
        if (ch == CH_COLON && prev2 == CH_N && prev1 == CH_M && nm_st == NM_IDLE) begin
            nm_val  = '0;
            nm_st   = NM_SKIP;
            nm_wait = 2'd2;
        end
        win = {prev1, ch};
    endfunction

    function automatic void parse_byte(input logic [7:0] ch, input logic last,
                                       output logic done, output result_t sum);
        logic [32:0] total;
        sum  = '0;
        done = last;
        if (fld_cnt < MANDATORY_FIELDS) begin
            if (ch == CH_TAB) begin
                fld_cnt++;
                num_halt = 1'b0;
                if (fld_cnt == MANDATORY_FIELDS) win = '0;
            end else if (fld_cnt == FIELD_FLAG || fld_cnt == FIELD_POS) begin
                if (!num_halt && !is_num_char(ch)) begin
                    num_halt = 1'b1;
                end else if (!num_halt && fld_cnt == FIELD_FLAG) begin
                    flag_val = add_digit(flag_val, ch, FLAG_MAX);
                end else if (!num_halt) begin
                    pos_val = add_digit(pos_val, ch, POS_MAX);
                end
            end else if (fld_cnt == FIELD_CIGAR) begin
                if (is_num_char(ch)) begin
                    run_len = add_digit(run_len, ch, POS_MAX);
                end else begin
                    if (ch == CH_M || ch == CH_D || ch == CH_I) begin
                        total = 33'(len_sum) + 33'(run_len);
                        len_sum = (total > 33'(POS_MAX)) ? POS_MAX : total[31:0];
                    end
                    run_len = '0;
                end
            end
        end else begin
            tag_byte(ch);
        end
        if (!last) return;
        sum.mismatch_count = MD_NONE;
        sum.edit_distance  = NM_NONE;
        if (fld_cnt + 1 >= MANDATORY_FIELDS) begin
            sum.record_ok        = 1'b1;
            sum.flag_value       = flag_val[15:0];
            sum.ref_position     = pos_val[30:0];
            sum.forward_strand   = ~flag_val[4];
            sum.unmapped         = flag_val[2];
            sum.alignment_length = flag_val[2] ? 31'd0 : len_sum[30:0];
            sum.mismatch_count   = md_cnt;
            sum.edit_distance    = nm_val;
        end
        clear_parser();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    function automatic void add_text(input string t);
        int i;
        for (i = 0; i < t.len(); i++) line_buf.push_back(t[i]);
    endfunction

    function automatic void send_line(input logic known, input result_t val);
        beat_t b;
        int    i;
        for (i = 0; i < line_buf.size(); i++) begin
            b.ch   = line_buf[i];
            b.last = (i == line_buf.size() - 1);
            tx_q.push_back(b);
        end
        fixed_q.push_back({known, val});
        line_buf.delete();
    endfunction

    function automatic string rand_digits(input int unsigned lo, input int unsigned hi);
        string       s;
        int unsigned n;
        int unsigned i;
        s = "";
        n = $urandom_range(hi, lo);
        for (i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
        return s;
    endfunction

    function automatic string rand_number();
        case ($urandom_range(9))
            0: return "";
            1: return rand_digits(11, 14);
            2: return {"-", rand_digits(1, 3)};
            3: return {rand_digits(1, 3), "x9"};
            4: return $sformatf("%0d", $urandom_range(65535));
            5: return $sformatf("%0d", $urandom);
            8: return {" ", rand_digits(1, 2)};
            default: return $sformatf("%0d", $urandom_range(40));
        endcase
    endfunction

    function automatic string rand_md();
        string       s;
        string       bases;
        int unsigned n;
        int unsigned i;
        int unsigned k;
        s = "";
        bases = "ACGTN";
        n = $urandom_range(6);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: s = {s, $sformatf("%0d", $urandom_range(20))};
                1: s = {s, $sformatf("%c", bases[$urandom_range(4)])};
                2: begin
                    s = {s, "^"};
                    k = $urandom_range(3, 1);
                    repeat (k) s = {s, $sformatf("%c", bases[$urandom_range(4)])};
                end
                default: s = {s, $sformatf("%c", $urandom_range(126, 33))};
            endcase
        end
        return s;
    endfunction

    function automatic string rand_text();
        string       s;
        int unsigned n;
        int unsigned i;
        s = "";
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(5))
                0: s = {s, "MD:"};
                1: s = {s, "NM:"};
                default: s = {s, $sformatf("%c", $urandom_range(126, 33))};
            endcase
        end
        return s;
    endfunction

    function automatic void make_line();
        string       ops;
        int unsigned n;
        int unsigned i;
        int unsigned cut;
        ops = "MIDNSHP=X";
        line_buf.delete();
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(30, 1);
            for (i = 0; i < n; i++) begin
                line_buf.push_back(($urandom_range(3) == 0) ? CH_TAB : 8'($urandom_range(255)));
            end
            return;
        end
        add_text({rand_text(), "\t", rand_number(), "\tc\t", rand_number(), "\t",
                  $sformatf("%0d", $urandom_range(60)), "\t"});
        n = $urandom_range(4);
        for (i = 0; i < n; i++) add_text({rand_number(), $sformatf("%c", ops[$urandom_range(8)])});
        add_text("\t*\t0\t0\tACGT\t*");
        n = $urandom_range(3);
        for (i = 0; i < n; i++) begin
            add_text("\t");
            case ($urandom_range(4))
                0: add_text({"NM:i:", rand_number()});
                1, 2: add_text({"MD:Z:", rand_md()});
                3: add_text({"XA:Z:", rand_text()});
                default: begin
                    repeat ($urandom_range(4, 1)) line_buf.push_back(8'($urandom_range(255)));
                end
            endcase
        end
        if ($urandom_range(7) == 0) begin
            cut = $urandom_range(line_buf.size() - 1, 1);
            repeat (cut) void'(line_buf.pop_back());
        end
    endfunction

    task automatic settle();
        while (fixed_q.size() != 0 || summary_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tx_q[0].ch;
                s_tlast  <= tx_q[0].last;
                void'(tx_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_ack != hold_seq) begin
            hold_ack  <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        logic    done;
        fixed_t  fx;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast, done, want);
                if (done) begin
                    fx = fixed_q.pop_front();
                    summary_q.push_back(fx.known ? fx.val : want);
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_BITS-1:0];
                if (summary_q.size() == 0) begin
                    $display("%0t: unexpected summary beat, expected none, got %0h", $time, got);
                    err_count++;
                end else begin
                    want = summary_q.pop_front();
                    check_field("record_ok", 32'(want.record_ok), 32'(got.record_ok));
                    check_field("flag_value", 32'(want.flag_value), 32'(got.flag_value));
                    check_field("ref_position", 32'(want.ref_position),
                                32'(got.ref_position));
                    check_field("forward_strand", 32'(want.forward_strand),
                                32'(got.forward_strand));
                    check_field("unmapped", 32'(want.unmapped), 32'(got.unmapped));
                    check_field("alignment_length", 32'(want.alignment_length),
                                32'(got.alignment_length));
                    check_field("mismatch_count", 32'(want.mismatch_count),
                                32'(got.mismatch_count));
                    check_field("edit_distance", want.edit_distance, got.edit_distance);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int      row;
        int      ph;
        int      lines;
        int      bytes;
        result_t r;
        clear_parser();
        for (row = 0; row < DIR_ROWS; row++) dir_fix[row] = '0;
        r = '0;
        r.mismatch_count = MD_NONE;
        r.edit_distance  = NM_NONE;
        dir_fix[0] = {1'b1, r};
        dir_fix[2] = {1'b1, r};
        r.record_ok      = 1'b1;
        r.forward_strand = 1'b1;
        dir_fix[1] = {1'b1, r};
        r.ref_position     = 31'd1;
        r.alignment_length = POS_MAX[30:0];
        dir_fix[5] = {1'b1, r};
        r.flag_value       = FLAG_MAX[15:0];
        r.ref_position     = POS_MAX[30:0];
        r.forward_strand   = 1'b0;
        r.unmapped         = 1'b1;
        r.alignment_length = 31'd0;
        r.mismatch_count   = 17'd0;
        r.edit_distance    = NM_MAX;
        dir_fix[4] = {1'b1, r};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < DIR_ROWS; row++) begin
            add_text(dir_text[row]);
            send_line(dir_fix[row].known, dir_fix[row].val);
        end
        settle();

        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct <= send_pct_of[ph];
            stall_pct     <= stall_pct_of[ph];
            if (ph == 0) hold_seq <= hold_seq + 1;
            @(posedge aclk);
            lines = 0;
            bytes = 0;
            while (bytes < 130 || lines < 2) begin
                make_line();
                bytes += line_buf.size();
                send_line(1'b0, '0);
                lines++;
            end
            settle();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
